### rtl/lpml_pkg.sv
// Package: shared types, codes and helper functions of the LPM route lookup.
`timescale 1ns / 1ps
`default_nettype none
package lpml_pkg;

  // Default table depth and number of known interfaces.
  localparam int LPML_ENTRIES     = 16;
  localparam int LPML_IFACE_COUNT = 16;

  // Field widths fixed by the item format.
  localparam int LPML_ADDR_W  = 32;
  localparam int LPML_IFACE_W = 4;
  localparam int LPML_LEN_W   = 6;
  localparam int LPML_IDX_W   = 4;

  // Item opcodes.
  localparam logic LPML_OP_WRITE  = 1'b0;
  localparam logic LPML_OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic                    op;
    logic [LPML_IDX_W-1:0]   slot_index;
    logic [LPML_ADDR_W-1:0]  route_prefix;
    logic [LPML_ADDR_W-1:0]  route_mask;
    logic [LPML_IFACE_W-1:0] route_iface;
    logic                    route_valid;
    logic [LPML_ADDR_W-1:0]  lookup_addr;
  } lpml_in_t;

  typedef struct packed {
    logic                    hit;
    logic [LPML_IFACE_W-1:0] out_iface;
    logic [LPML_LEN_W-1:0]   prefix_len;
    logic [LPML_IDX_W-1:0]   best_slot;
  } lpml_out_t;

  // One stored route; the mask length is worked out when the slot is written.
  typedef struct packed {
    logic [LPML_ADDR_W-1:0]  prefix;
    logic [LPML_ADDR_W-1:0]  mask;
    logic [LPML_IFACE_W-1:0] iface;
    logic [LPML_LEN_W-1:0]   len;
  } lpml_entry_t;

  // Status of the registered table read port.
  typedef struct packed {
    logic strobe;  // read data is fresh this cycle
    logic used;    // slot valid bit
  } lpml_rd_t;

  // Running best match of a lookup.
  typedef struct packed {
    logic                    found;
    logic [LPML_LEN_W-1:0]   len;
    logic [LPML_IFACE_W-1:0] iface;
  } lpml_best_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } lpml_state_t;

  // Count leading ones from bit 31 by halving: five narrow steps.
  function automatic logic [LPML_LEN_W-1:0] lpml_lead_ones(input logic [LPML_ADDR_W-1:0] m);
    logic [LPML_ADDR_W-1:0] x;
    logic [LPML_LEN_W-1:0]  n;
    x = m;
    n = '0;
    if (&m) begin
      n = 6'd32;
    end else begin
      if (&x[31:16]) begin
        n = n + 6'd16;
        x = x << 16;
      end
      if (&x[31:24]) begin
        n = n + 6'd8;
        x = x << 8;
      end
      if (&x[31:28]) begin
        n = n + 6'd4;
        x = x << 4;
      end
      if (&x[31:30]) begin
        n = n + 6'd2;
        x = x << 2;
      end
      if (x[31]) begin
        n = n + 6'd1;
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

### rtl/lpml_table.sv
// Route table: slot memory with one write port, one registered read port, valid flops.
`timescale 1ns / 1ps
`default_nettype none
module lpml_table #(
  parameter int ENTRIES = lpml_pkg::LPML_ENTRIES,
  parameter int SLOT_W  = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire logic [SLOT_W-1:0]    wr_addr,
  input  wire lpml_pkg::lpml_entry_t wr_entry,
  input  wire logic                 wr_valid,
  input  wire logic                 rd_en,
  input  wire logic [SLOT_W-1:0]    rd_addr,
  output lpml_pkg::lpml_rd_t        rd_stat,
  output lpml_pkg::lpml_entry_t     rd_entry,
  output logic [SLOT_W-1:0]         rd_slot
);
  import lpml_pkg::*;

  lpml_entry_t        mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  lpml_entry_t        rd_entry_r;
  logic [SLOT_W-1:0]  rd_slot_r;
  logic               strobe_r;
  logic               used_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry_r <= mem[rd_addr];
      rd_slot_r  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      strobe_r <= 1'b0;
      used_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= wr_valid;
      end
      strobe_r <= rd_en;
      if (rd_en) begin
        used_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_stat.strobe = strobe_r;
  assign rd_stat.used   = used_r;
  assign rd_entry       = rd_entry_r;
  assign rd_slot        = rd_slot_r;

endmodule
`default_nettype wire

### rtl/lpml_match.sv
// Shared compare unit: tests one slot per cycle and keeps the best match so far.
`timescale 1ns / 1ps
`default_nettype none
module lpml_match #(
  parameter int SLOT_W = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   clear,
  input  wire lpml_pkg::lpml_rd_t     rd_stat,
  input  wire lpml_pkg::lpml_entry_t  entry,
  input  wire logic [SLOT_W-1:0]      slot,
  input  wire logic [lpml_pkg::LPML_ADDR_W-1:0] addr,
  output lpml_pkg::lpml_best_t        best,
  output logic [SLOT_W-1:0]           best_slot
);
  import lpml_pkg::*;

  logic                    found_r;
  logic [LPML_LEN_W-1:0]   len_r;
  logic [LPML_IFACE_W-1:0] iface_r;
  logic [SLOT_W-1:0]       slot_r;
  logic                    same_net;
  logic                    longer;
  logic                    take;

  assign same_net = ((addr ^ entry.prefix) & entry.mask) == '0;
  assign longer   = !found_r || (entry.len > len_r);
  assign take     = rd_stat.strobe && rd_stat.used && longer && same_net;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (clear) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !clear) begin
      len_r   <= entry.len;
      iface_r <= entry.iface;
      slot_r  <= slot;
    end
  end

  assign best.found = found_r;
  assign best.len   = len_r;
  assign best.iface = iface_r;
  assign best_slot  = slot_r;

endmodule
`default_nettype wire

### rtl/longest_prefix_match_lookup_unit.sv
// Top level: IPv4 longest-prefix-match route lookup with a sequenced slot scan.
// Write item: stores the route at the accepting edge, no result.
// Lookup item: reads and compares every slot in turn (one table read and one compare
//   per slot through the single read port and the shared compare unit); the next item
//   is taken only after the result has been loaded into the output register.
// Reset: synchronous, active low; clears the slot valid bits at once (empty table).
`timescale 1ns / 1ps
`default_nettype none
module longest_prefix_match_lookup_unit #(
  parameter int ENTRIES = lpml_pkg::LPML_ENTRIES
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire lpml_pkg::lpml_in_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lpml_pkg::lpml_out_t      out_item
);
  import lpml_pkg::*;

  localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);

  lpml_state_t state_r;
  lpml_state_t state_nxt;

  logic [SLOT_W-1:0]      idx_r;
  logic [SLOT_W-1:0]      idx_nxt;
  logic [LPML_ADDR_W-1:0] addr_r;

  logic in_xfer;
  logic wr_en;
  logic start;
  logic rd_en;
  logic out_load;

  lpml_entry_t       wr_entry;
  lpml_rd_t          rd_stat;
  lpml_entry_t       rd_entry;
  logic [SLOT_W-1:0] rd_slot;
  lpml_best_t        best;
  logic [SLOT_W-1:0] best_slot;

  logic      out_valid_r;
  lpml_out_t out_item_r;
  lpml_out_t result;

  // Accept only while idle; a waiting result sits in the output register.
  assign in_xfer = in_valid && !in_stall;
  assign start   = in_xfer && (in_item.op == LPML_OP_LOOKUP);
  // Drop writes aimed past the end of the table.
  assign wr_en   = in_xfer && (in_item.op == LPML_OP_WRITE) &&
                   (32'(in_item.slot_index) < ENTRIES);

  assign wr_entry.prefix = in_item.route_prefix;
  assign wr_entry.mask   = in_item.route_mask;
  assign wr_entry.iface  = in_item.route_iface;
  assign wr_entry.len    = lpml_lead_ones(in_item.route_mask);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_r == LAST_SLOT) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    out_load = 1'b0;
    idx_nxt  = idx_r;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        idx_nxt  = '0;
      end
      ST_SCAN: begin
        rd_en   = 1'b1;
        idx_nxt = idx_r + 1'b1;
      end
      ST_DRAIN: begin
        // Last slot is being compared.
      end
      ST_DONE: begin
        // Hold the finished result until the output register frees up.
        out_load = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      addr_r <= in_item.lookup_addr;
    end
  end

  lpml_table #(
    .ENTRIES (ENTRIES),
    .SLOT_W  (SLOT_W)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (SLOT_W'(in_item.slot_index)),
    .wr_entry (wr_entry),
    .wr_valid (in_item.route_valid),
    .rd_en    (rd_en),
    .rd_addr  (idx_r),
    .rd_stat  (rd_stat),
    .rd_entry (rd_entry),
    .rd_slot  (rd_slot)
  );

  lpml_match #(
    .SLOT_W (SLOT_W)
  ) u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (start),
    .rd_stat   (rd_stat),
    .entry     (rd_entry),
    .slot      (rd_slot),
    .addr      (addr_r),
    .best      (best),
    .best_slot (best_slot)
  );

  // A winner with an unknown interface still shadows shorter routes but reports no hit.
  always_comb begin
    result = '0;
    if (best.found && (32'(best.iface) < LPML_IFACE_COUNT)) begin
      result.hit        = 1'b1;
      result.out_iface  = best.iface;
      result.prefix_len = best.len;
      result.best_slot  = LPML_IDX_W'(best_slot);
    end
  end

  // Output register: advance on load, clear once the transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

### rtl/lpml_checker.sv
// Port-level checker for the LPM route lookup and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lpml_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire lpml_pkg::lpml_in_t  in_item,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire lpml_pkg::lpml_out_t out_item
);
  import lpml_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed or vanished while stalled");

  a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_item.op == LPML_OP_WRITE) |=> !in_stall)
    else $error("route write did not complete in one cycle");

  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_item.op == LPML_OP_LOOKUP) |=> in_stall)
    else $error("lookup accepted but block still taking items");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.hit |->
      (out_item.out_iface == '0) && (out_item.prefix_len == '0) &&
      (out_item.best_slot == '0))
    else $error("miss result carries nonzero fields");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.prefix_len <= 6'd32)
    else $error("prefix length out of range");

endmodule

bind longest_prefix_match_lookup_unit lpml_checker u_lpml_checker (.*);
`default_nettype wire

### dv/longest_prefix_match_lookup_unit_tb.sv
// Testbench for the LPM route lookup unit: directed route cases, then random table traffic.
`timescale 1ns / 1ps
module longest_prefix_match_lookup_unit_tb;
  import lpml_pkg::*;

  localparam int SLOTS     = LPML_ENTRIES;
  localparam int RUN_LIMIT = 200000;

  // Receiver stall behavior; each one lasts for a random stretch of cycles.
  typedef enum {RX_OPEN, RX_SPARSE, RX_LONG, RX_HEAVY} rx_mode_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  lpml_in_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  lpml_out_t out_item;

  // Shadow route table, updated at each accepted write transfer.
  logic [LPML_ADDR_W-1:0]  rt_prefix [SLOTS];
  logic [LPML_ADDR_W-1:0]  rt_mask   [SLOTS];
  logic [LPML_IFACE_W-1:0] rt_iface  [SLOTS];
  logic                    rt_used   [SLOTS];

  // Route answers owed by the unit, oldest first.
  lpml_out_t route_answers[$];

  int error_count = 0;
  int cycle_count = 0;
  int burst_left  = 0;

  rx_mode_t rx_mode   = RX_OPEN;
  int       mode_left = 0;
  int       hold_left = 0;

  longest_prefix_match_lookup_unit #(.ENTRIES(SLOTS)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bail out if the run hangs; the limit is many times the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("longest_prefix_match_lookup_unit: mismatch");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      rt_prefix[i] = '0;
      rt_mask[i]   = '0;
      rt_iface[i]  = '0;
      rt_used[i]   = 1'b0;
    end
  end

  // Count leading ones of a netmask, starting at bit 31.
  function automatic logic [LPML_LEN_W-1:0] mask_length(input logic [LPML_ADDR_W-1:0] m);
    int n;
    n = 0;
    while (n < LPML_ADDR_W && m[LPML_ADDR_W-1-n]) n++;
    return n[LPML_LEN_W-1:0];
  endfunction

  function automatic logic [LPML_ADDR_W-1:0] netmask(input int len);
    if (len <= 0) return '0;
    return {LPML_ADDR_W{1'b1}} << (LPML_ADDR_W - len);
  endfunction

  // Store a route into the shadow table. Writes past the table end are dropped.
  function automatic void commit_route(input lpml_in_t it);
    if (int'(it.slot_index) < SLOTS) begin
      rt_prefix[it.slot_index] = it.route_prefix;
      rt_mask[it.slot_index]   = it.route_mask;
      rt_iface[it.slot_index]  = it.route_iface;
      rt_used[it.slot_index]   = it.route_valid;
    end
  endfunction

  // Work out the best route for an address: scan from slot 0 and replace the
  // current best only on a strictly longer mask, so the lowest slot wins a tie.
  function automatic lpml_out_t resolve_route(input logic [LPML_ADDR_W-1:0] addr);
    logic                  found;
    logic [LPML_LEN_W-1:0] best_len;
    logic [LPML_LEN_W-1:0] len;
    int                    best_idx;
    lpml_out_t             r;
    found    = 1'b0;
    best_len = '0;
    best_idx = 0;
    r        = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (rt_used[i]) begin
        len = mask_length(rt_mask[i]);
        if ((!found || len > best_len) &&
            ((addr & rt_mask[i]) == (rt_prefix[i] & rt_mask[i]))) begin
          found    = 1'b1;
          best_len = len;
          best_idx = i;
        end
      end
    end
    // A winner naming no known interface still shadows shorter routes but
    // reports as a miss.
    if (found && int'(rt_iface[best_idx]) < LPML_IFACE_COUNT) begin
      r.hit        = 1'b1;
      r.out_iface  = rt_iface[best_idx];
      r.prefix_len = best_len;
      r.best_slot  = best_idx[LPML_IDX_W-1:0];
    end
    return r;
  endfunction

  // Predict at each input transfer and check each output transfer. Both read
  // the values present before the edge, as the unit does.
  always @(posedge clk) begin : scoreboard
    lpml_out_t want;
    if (rst_n && in_valid && !in_stall) begin
      if (in_item.op == LPML_OP_WRITE) begin
        commit_route(in_item);
      end else begin
        route_answers.push_back(resolve_route(in_item.lookup_addr));
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      if (route_answers.size() == 0) begin
        $error("unexpected result transfer: hit=%0d iface=%0d len=%0d slot=%0d",
               out_item.hit, out_item.out_iface, out_item.prefix_len, out_item.best_slot);
        error_count++;
      end else begin
        want = route_answers.pop_front();
        if (out_item.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_item.hit);
          error_count++;
        end
        if (out_item.out_iface !== want.out_iface) begin
          $error("out_iface: expected %0d, got %0d", want.out_iface, out_item.out_iface);
          error_count++;
        end
        if (out_item.prefix_len !== want.prefix_len) begin
          $error("prefix_len: expected %0d, got %0d", want.prefix_len, out_item.prefix_len);
          error_count++;
        end
        if (out_item.best_slot !== want.best_slot) begin
          $error("best_slot: expected %0d, got %0d", want.best_slot, out_item.best_slot);
          error_count++;
        end
      end
    end
  end

  // Receiver: switch between open, sparse, long-hold and heavy stall patterns.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      rx_mode   <= rx_mode_t'($urandom_range(0, 3));
      mode_left <= $urandom_range(20, 150);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (rx_mode)
      RX_OPEN: begin
        out_stall <= 1'b0;
      end
      RX_SPARSE: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      RX_LONG: begin
        // Toggle after each hold; stalls run long, open windows short.
        if (hold_left == 0) begin
          out_stall <= !out_stall;
          hold_left <= out_stall ? $urandom_range(1, 6) : $urandom_range(1, 24);
        end else begin
          hold_left <= hold_left - 1;
        end
      end
      default: begin
        out_stall <= ($urandom_range(0, 3) != 0);
      end
    endcase
  end

  // Sender: present one item and hold it until the transfer. Between bursts,
  // drop valid for a random gap; an occasional long burst runs without gaps.
  task automatic send_item(input lpml_in_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // The address field is unused on a write; fill it with noise.
  function automatic lpml_in_t route_write(input int slot, input logic [31:0] prefix,
                                           input logic [31:0] mask, input int iface,
                                           input bit used);
    lpml_in_t it;
    it.op           = LPML_OP_WRITE;
    it.slot_index   = slot[LPML_IDX_W-1:0];
    it.route_prefix = prefix;
    it.route_mask   = mask;
    it.route_iface  = iface[LPML_IFACE_W-1:0];
    it.route_valid  = used;
    it.lookup_addr  = $urandom();
    return it;
  endfunction

  // The route fields are unused on a lookup; fill them with noise.
  function automatic lpml_in_t route_query(input logic [31:0] addr);
    lpml_in_t it;
    it.op           = LPML_OP_LOOKUP;
    it.slot_index   = LPML_IDX_W'($urandom_range(0, 15));
    it.route_prefix = $urandom();
    it.route_mask   = $urandom();
    it.route_iface  = LPML_IFACE_W'($urandom_range(0, 15));
    it.route_valid  = ($urandom_range(0, 1) != 0);
    it.lookup_addr  = addr;
    return it;
  endfunction

  // After reset the table is empty: every lookup misses.
  task automatic test_empty_table();
    send_item(route_query(32'h0000_0000));
    send_item(route_query(32'hFFFF_FFFF));
  endtask

  // A zero mask matches any address with length 0.
  task automatic test_default_route();
    send_item(route_write(5, $urandom(), 32'h0, 3, 1'b1));
    send_item(route_query($urandom()));
  endtask

  // Host route at the field extremes; one bit off falls back to the default.
  task automatic test_host_route();
    send_item(route_write(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15, 1'b1));
    send_item(route_query(32'hFFFF_FFFF));
    send_item(route_query(32'hFFFF_FFFE));
  endtask

  // Same length in two slots: the lower slot wins. Prefix bits under a zero
  // mask bit must not matter.
  task automatic test_equal_length_tie();
    send_item(route_write(2, 32'h0A00_0000, netmask(8), 1, 1'b1));
    send_item(route_write(9, 32'h0AFF_FFFF, netmask(8), 7, 1'b1));
    send_item(route_query(32'h0A01_0203));
  endtask

  // A longer route in a later slot beats an earlier shorter one.
  task automatic test_longer_route_later();
    send_item(route_write(15, 32'h0A01_0200, netmask(24), 4, 1'b1));
    send_item(route_query(32'h0A01_02FE));
  endtask

  // Holes in a mask: every mask bit takes part in the compare, but the length
  // counts only the leading ones.
  task automatic test_noncontiguous_mask();
    send_item(route_write(7, 32'hC0A8_0064, 32'hFF00_FF00, 9, 1'b1));
    send_item(route_query(32'hC012_0034));
    send_item(route_query(32'hC0A8_FF64));
  endtask

  // Clearing the valid bit takes a slot out of the scan.
  task automatic test_slot_clear();
    send_item(route_write(0, $urandom(), $urandom(), $urandom_range(0, 15), 1'b0));
    send_item(route_write(5, $urandom(), $urandom(), $urandom_range(0, 15), 1'b0));
    send_item(route_query(32'hFFFF_FFFF));
  endtask

  // Mostly well-formed routes that nest on each other's prefixes, and lookups
  // aimed inside stored routes; the rest is noise masks and random addresses.
  // Slot and interface fields are 4 bits wide, so with a 16-entry table and 16
  // interfaces no write lands past the end and every interface id is known.
  task automatic test_random_traffic(input int count);
    int               pick;
    int               slot;
    int               len;
    logic [31:0]      base;
    logic [31:0]      keep;
    logic [31:0]      mask;
    logic [31:0]      addr;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      slot = $urandom_range(0, SLOTS - 1);
      if (pick < 30) begin
        case ($urandom_range(0, 3))
          0: len = 8 * $urandom_range(0, 4);
          default: len = $urandom_range(0, 32);
        endcase
        mask = netmask(len);
        base = rt_prefix[$urandom_range(0, SLOTS - 1)];
        keep = netmask($urandom_range(4, 28));
        if ($urandom_range(0, 1)) base = (base & keep) | ($urandom() & ~keep);
        else base = $urandom();
        send_item(route_write(slot, base, mask, $urandom_range(0, 15),
                              $urandom_range(0, 9) != 0));
      end else if (pick < 36) begin
        send_item(route_write(slot, $urandom(), $urandom(), $urandom_range(0, 15),
                              $urandom_range(0, 1) != 0));
      end else begin
        if (rt_used[slot] && $urandom_range(0, 9) < 7) begin
          addr = (rt_prefix[slot] & rt_mask[slot]) | ($urandom() & ~rt_mask[slot]);
        end else begin
          case ($urandom_range(0, 9))
            0: addr = 32'h0000_0000;
            1: addr = 32'hFFFF_FFFF;
            default: addr = $urandom();
          endcase
        end
        send_item(route_query(addr));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_default_route();
    test_host_route();
    test_equal_length_tie();
    test_longer_route_later();
    test_noncontiguous_mask();
    test_slot_clear();
    test_random_traffic(400);

    // Drop valid after the last transfer, drain owed answers, then allow one
    // full scan for anything unexpected to show.
    in_valid <= 1'b0;
    @(posedge clk);
    while (route_answers.size() != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);

    if (error_count == 0) begin
      $display("longest_prefix_match_lookup_unit: match");
    end else begin
      $display("longest_prefix_match_lookup_unit: mismatch");
    end
    $finish;
  end

endmodule

### files.f
rtl/lpml_pkg.sv
rtl/lpml_table.sv
rtl/lpml_match.sv
rtl/longest_prefix_match_lookup_unit.sv
rtl/lpml_checker.sv
dv/longest_prefix_match_lookup_unit_tb.sv
